// ----- rtl/hsv_to_rgb_converter_macros.svh -----
// Assertion macros shared by the converter modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// cond must hold in the same cycle as pre
`define HSV_CHK_IMPLY(label, pre, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (cond)) \
		else $error("hsv2rgb: check failed");

// cond must hold in the cycle after pre
`define HSV_CHK_NEXT(label, pre, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (cond)) \
		else $error("hsv2rgb: check failed");

`endif

// ----- rtl/hsv2rgb_pkg.sv -----
`default_nettype none
package hsv2rgb_pkg;

	localparam int unsigned HUE_FULL   = 360;
	localparam int unsigned HUE_SECTOR = 60;
	localparam int unsigned LEVEL_MAX  = 255;
	localparam int unsigned FRAC_DEN   = 15300;

	// multiple of 360 that lifts any 16-bit signed hue to a positive value
	localparam logic [16:0] HUE_BIAS = 17'(92 * HUE_FULL);

	// reciprocals: floor(x/d) = (x*K) >> S, exact over the ranges used here
	localparam logic [15:0] RECIP_360   = 16'd46604;   // S = 24, x <= 65887
	localparam logic [16:0] RECIP_255   = 17'd65794;   // S = 24, x <= 65025
	localparam logic [22:0] RECIP_15300 = 23'd4491470; // S = 36, x <= 3901500
	localparam logic [10:0] RECIP_15300_HI = RECIP_15300[22:12];
	localparam logic [11:0] RECIP_15300_LO = RECIP_15300[11:0];

	typedef enum logic [2:0] {
		SEC_RY = 3'd0,
		SEC_YG = 3'd1,
		SEC_GC = 3'd2,
		SEC_CB = 3'd3,
		SEC_BM = 3'd4,
		SEC_MR = 3'd5
	} sector_t;

	typedef struct packed {
		logic        vld;
		logic [16:0] hue_x;   // biased hue, always positive
		logic [7:0]  sat;
		logic [7:0]  val;
	} in_word_t;

	typedef struct packed {
		logic       vld;
		sector_t    sector;
		logic [5:0] rem;
		logic [7:0] sat;
		logic [7:0] val;
	} hsv_word_t;

	typedef struct packed {
		logic       vld;
		sector_t    sector;
		logic [7:0] val;
		logic [7:0] lvl_m;
		logic [7:0] lvl_n;
		logic [7:0] lvl_k;
	} lvl_word_t;

endpackage
`default_nettype wire

// ----- rtl/hsv2rgb_sector.sv -----
`default_nettype none
`include "hsv_to_rgb_converter_macros.svh"
module hsv2rgb_sector
	import hsv2rgb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire in_word_t  in_s1,
	output hsv_word_t      out_s4
);

	logic        vld_s2, vld_s3, vld_s4;
	logic [16:0] x_s2;
	logic [7:0]  q_s2;
	logic [7:0]  sat_s2, val_s2, sat_s3, val_s3, sat_s4, val_s4;
	logic [8:0]  hue_s3;
	sector_t     sector_s4;
	logic [5:0]  rem_s4;

	logic [32:0] q_prod;
	logic [16:0] q_times;
	logic [16:0] hue_diff;
	sector_t     sector_c;
	logic [5:0]  rem_c;

	always_comb begin
		q_prod   = 33'(in_s1.hue_x) * 33'(RECIP_360);
		q_times  = 17'(q_s2) * 17'(HUE_FULL);
		hue_diff = x_s2 - q_times;
	end

	always_comb begin
		priority if (hue_s3 < 9'(HUE_SECTOR)) begin
			sector_c = SEC_RY;
			rem_c    = 6'(hue_s3);
		end else if (hue_s3 < 9'(2 * HUE_SECTOR)) begin
			sector_c = SEC_YG;
			rem_c    = 6'(hue_s3 - 9'(HUE_SECTOR));
		end else if (hue_s3 < 9'(3 * HUE_SECTOR)) begin
			sector_c = SEC_GC;
			rem_c    = 6'(hue_s3 - 9'(2 * HUE_SECTOR));
		end else if (hue_s3 < 9'(4 * HUE_SECTOR)) begin
			sector_c = SEC_CB;
			rem_c    = 6'(hue_s3 - 9'(3 * HUE_SECTOR));
		end else if (hue_s3 < 9'(5 * HUE_SECTOR)) begin
			sector_c = SEC_BM;
			rem_c    = 6'(hue_s3 - 9'(4 * HUE_SECTOR));
		end else begin
			sector_c = SEC_MR;
			rem_c    = 6'(hue_s3 - 9'(5 * HUE_SECTOR));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= in_s1.vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s2      <= in_s1.hue_x;
		q_s2      <= q_prod[31:24];
		sat_s2    <= in_s1.sat;
		val_s2    <= in_s1.val;
		hue_s3    <= hue_diff[8:0];
		sat_s3    <= sat_s2;
		val_s3    <= val_s2;
		sector_s4 <= sector_c;
		rem_s4    <= rem_c;
		sat_s4    <= sat_s3;
		val_s4    <= val_s3;
	end

	assign out_s4 = '{vld: vld_s4, sector: sector_s4, rem: rem_s4, sat: sat_s4, val: val_s4};

	`HSV_CHK_IMPLY(a_hue_wrapped, vld_s3, hue_s3 < 9'(HUE_FULL))
	`HSV_CHK_NEXT(a_rem_range, vld_s3, rem_s4 < 6'(HUE_SECTOR))

endmodule
`default_nettype wire

// ----- rtl/hsv2rgb_levels.sv -----
`default_nettype none
`include "hsv_to_rgb_converter_macros.svh"
module hsv2rgb_levels
	import hsv2rgb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire hsv_word_t  in_s4,
	output lvl_word_t       out_s8
);

	logic       vld_s5, vld_s6, vld_s7, vld_s8;
	sector_t    sector_s5, sector_s6, sector_s7, sector_s8;
	logic [7:0] val_s5, val_s6, val_s7, val_s8;

	logic [7:0]  num_m_s5;
	logic [13:0] num_n_s5, num_k_s5;
	logic [15:0] prod_m_s6;
	logic [21:0] prod_n_s6, prod_k_s6;
	logic [7:0]  lvl_m_s7, lvl_m_s8;
	logic [33:0] pp_n_lo_s7, pp_k_lo_s7;
	logic [32:0] pp_n_hi_s7, pp_k_hi_s7;
	logic [7:0]  lvl_n_s8, lvl_k_s8;

	logic [13:0] rs_n, rs_k;
	logic [5:0]  rem_rev;
	logic [32:0] div_m;
	logic [45:0] sum_n, sum_k;

	always_comb begin
		rem_rev = 6'(HUE_SECTOR) - in_s4.rem;
		rs_n    = 14'(in_s4.rem) * 14'(in_s4.sat);
		rs_k    = 14'(rem_rev) * 14'(in_s4.sat);
		div_m   = 33'(prod_m_s6) * 33'(RECIP_255);
		// x * RECIP_15300 split in two partial products, registered in s7 and summed into s8
		sum_n   = {1'b0, pp_n_hi_s7, 12'd0} + 46'(pp_n_lo_s7);
		sum_k   = {1'b0, pp_k_hi_s7, 12'd0} + 46'(pp_k_lo_s7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s5 <= in_s4.vld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		sector_s5  <= in_s4.sector;
		val_s5     <= in_s4.val;
		num_m_s5   <= 8'(LEVEL_MAX) - in_s4.sat;
		num_n_s5   <= 14'(FRAC_DEN) - rs_n;
		num_k_s5   <= 14'(FRAC_DEN) - rs_k;

		sector_s6  <= sector_s5;
		val_s6     <= val_s5;
		prod_m_s6  <= 16'(val_s5) * 16'(num_m_s5);
		prod_n_s6  <= 22'(val_s5) * 22'(num_n_s5);
		prod_k_s6  <= 22'(val_s5) * 22'(num_k_s5);

		sector_s7  <= sector_s6;
		val_s7     <= val_s6;
		lvl_m_s7   <= div_m[31:24];
		pp_n_lo_s7 <= 34'(prod_n_s6) * 34'(RECIP_15300_LO);
		pp_n_hi_s7 <= 33'(prod_n_s6) * 33'(RECIP_15300_HI);
		pp_k_lo_s7 <= 34'(prod_k_s6) * 34'(RECIP_15300_LO);
		pp_k_hi_s7 <= 33'(prod_k_s6) * 33'(RECIP_15300_HI);

		sector_s8  <= sector_s7;
		val_s8     <= val_s7;
		lvl_m_s8   <= lvl_m_s7;
		lvl_n_s8   <= sum_n[43:36];
		lvl_k_s8   <= sum_k[43:36];
	end

	assign out_s8 = '{vld: vld_s8, sector: sector_s8, val: val_s8,
		lvl_m: lvl_m_s8, lvl_n: lvl_n_s8, lvl_k: lvl_k_s8};

	// zero saturation must leave the full numerators, so every level equals value
	`HSV_CHK_NEXT(a_grey_num, in_s4.vld && (in_s4.sat == 8'd0), (num_n_s5 == 14'(FRAC_DEN)) && (num_k_s5 == 14'(FRAC_DEN)))
	`HSV_CHK_IMPLY(a_lvl_order, vld_s8, (lvl_m_s8 <= lvl_n_s8) && (lvl_m_s8 <= lvl_k_s8) && (lvl_n_s8 <= val_s8) && (lvl_k_s8 <= val_s8))

endmodule
`default_nettype wire

// ----- rtl/hsv_to_rgb_converter.sv -----
// channel  | ports                          | handshake
// ---------+--------------------------------+-------------------------------
// input    | hue, saturation, brightness    | word taken when start && !busy
// result   | red, green, blue               | word valid while done is high
//
// One word per cycle; busy is never raised, so start may stay high.
// Each result shows up on done for one cycle, once its start has passed registers s1 to s9.
// The depth comes from the hue wrap (reciprocal multiply, subtract, sector
// split) and the level path (numerators, products, split reciprocal multiply).
// Reset clears only the valid bits; the receiver cannot stall the pipeline.
`default_nettype none
module hsv_to_rgb_converter
	import hsv2rgb_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] hue,
	input  wire logic signed [15:0] saturation,
	input  wire logic signed [15:0] brightness,
	output logic                    done,
	output logic             [7:0]  red,
	output logic             [7:0]  green,
	output logic             [7:0]  blue
);

	logic        vld_s1, vld_s9;
	logic [16:0] x_s1;
	logic [7:0]  sat_s1, val_s1;
	logic [7:0]  red_s9, green_s9, blue_s9;
	logic [7:0]  sat_c, val_c;
	logic [7:0]  r_c, g_c, b_c;

	in_word_t    in_s1;
	hsv_word_t   hsv_s4;
	lvl_word_t   lvl_s8;

	assign busy = 1'b0;

	always_comb begin
		priority if (saturation[15]) sat_c = 8'd0;
		else if (|saturation[14:8]) sat_c = 8'(LEVEL_MAX);
		else sat_c = saturation[7:0];

		priority if (brightness[15]) val_c = 8'd0;
		else if (|brightness[14:8]) val_c = 8'(LEVEL_MAX);
		else val_c = brightness[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s9 <= lvl_s8.vld;
		end
	end

	always_ff @(posedge clk) begin
		// sign extend then add the bias; the sum is always positive
		x_s1   <= {hue[15], hue} + HUE_BIAS;
		sat_s1 <= sat_c;
		val_s1 <= val_c;
	end

	assign in_s1 = '{vld: vld_s1, hue_x: x_s1, sat: sat_s1, val: val_s1};

	hsv2rgb_sector u_sector (
		.clk    (clk),
		.arst_n (arst_n),
		.in_s1  (in_s1),
		.out_s4 (hsv_s4)
	);

	hsv2rgb_levels u_levels (
		.clk    (clk),
		.arst_n (arst_n),
		.in_s4  (hsv_s4),
		.out_s8 (lvl_s8)
	);

	// grey needs no special case: with zero saturation all levels equal value
	always_comb begin
		unique case (lvl_s8.sector)
			SEC_RY: begin
				r_c = lvl_s8.val;   g_c = lvl_s8.lvl_k; b_c = lvl_s8.lvl_m;
			end
			SEC_YG: begin
				r_c = lvl_s8.lvl_n; g_c = lvl_s8.val;   b_c = lvl_s8.lvl_m;
			end
			SEC_GC: begin
				r_c = lvl_s8.lvl_m; g_c = lvl_s8.val;   b_c = lvl_s8.lvl_k;
			end
			SEC_CB: begin
				r_c = lvl_s8.lvl_m; g_c = lvl_s8.lvl_n; b_c = lvl_s8.val;
			end
			SEC_BM: begin
				r_c = lvl_s8.lvl_k; g_c = lvl_s8.lvl_m; b_c = lvl_s8.val;
			end
			SEC_MR: begin
				r_c = lvl_s8.val;   g_c = lvl_s8.lvl_m; b_c = lvl_s8.lvl_n;
			end
			default: begin
				r_c = lvl_s8.val;   g_c = lvl_s8.lvl_k; b_c = lvl_s8.lvl_m;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		red_s9   <= r_c;
		green_s9 <= g_c;
		blue_s9  <= b_c;
	end

	assign done  = vld_s9;
	assign red   = red_s9;
	assign green = green_s9;
	assign blue  = blue_s9;

endmodule
`default_nettype wire
